@@ rtl/core/tvss_pkg.sv @@
// Shared types and constants for the top-k vector similarity search block.
// No dependencies; imported by the core, the RAM users and the checker.
package tvss_pkg;

  // Parameter defaults
  localparam int unsigned DEF_MAX_VECTOR_LENGTH = 1024;
  localparam int unsigned DEF_MAX_KEPT          = 64;
  localparam int unsigned DEF_MAX_ENTRIES       = 65536;
  localparam int unsigned DEF_ELEMENT_BITS      = 16;

  // Fixed field widths
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned INDEX_W    = 16;
  localparam int unsigned SCORE_W    = 44;
  localparam int unsigned KEEP_REG_W = 7;
  localparam int unsigned LEN_REG_W  = 11;

  // APB register port
  localparam int unsigned APB_AW    = 4;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_METRIC = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEEP   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LEN    = 2'd2;

  localparam logic [KEEP_REG_W-1:0] KEEP_RESET = 7'd64;
  localparam logic [LEN_REG_W-1:0]  LEN_RESET  = 11'd1024;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DATA   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REPORT = 2'd2;

  // One entry of the ranked list
  typedef struct packed {
    logic [INDEX_W-1:0]        idx;
    logic signed [SCORE_W-1:0] score;
  } kept_t;

endpackage

@@ rtl/core/topk_vector_similarity_search.sv @@
// Top level of the brute-force top-k similarity search core.
// Depends on tvss_pkg and tvss_ram (query store and ranked-list memories).
//
// Query and database elements are taken one per cycle (start high, busy low). A
// database element passes a query-memory read, a multiply stage and an
// accumulate stage; the last element of a vector holds busy while it is in
// those stages and then through the ranked insert, which walks the kept-list
// memory from the tail one entry per cycle. A report holds busy while it reads
// the n kept entries, one memory read each, and strobes result_valid_o once per
// entry, best first, in the cycle after each read; an empty list gives a
// single strobe with entry_valid_o low. Results cannot be stalled: each one is
// on the ports for exactly one cycle. Neither memory needs a clearing pass after
// reset; the block is ready as soon as rst_ni rises.
module topk_vector_similarity_search
  import tvss_pkg::*;
#(
  parameter int unsigned MAX_VECTOR_LENGTH = DEF_MAX_VECTOR_LENGTH,
  parameter int unsigned MAX_KEPT          = DEF_MAX_KEPT,
  parameter int unsigned MAX_ENTRIES       = DEF_MAX_ENTRIES,
  parameter int unsigned ELEMENT_BITS      = DEF_ELEMENT_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // command channel
  input  logic                      start,
  output logic                      busy,
  input  logic [CMD_W-1:0]          cmd_i,
  input  logic signed [VALUE_W-1:0] element_value_i,
  input  logic [POS_W-1:0]          element_position_i,
  // register port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_AW-1:0]         paddr,
  input  logic [APB_DW-1:0]         pwdata,
  output logic [APB_DW-1:0]         prdata,
  output logic                      pready,
  // results
  output logic                      result_valid_o,
  output logic [INDEX_W-1:0]        entry_index_o,
  output logic signed [SCORE_W-1:0] entry_score_o,
  output logic                      entry_valid_o,
  output logic                      last_result_o
);

  localparam int unsigned QAW  = (MAX_VECTOR_LENGTH > 1) ? $clog2(MAX_VECTOR_LENGTH) : 1;
  localparam int unsigned KAW  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int unsigned KFW  = $clog2(MAX_KEPT + 1);
  localparam int unsigned CNTW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned OPW  = ELEMENT_BITS + 1;
  localparam int unsigned TW   = 2 * OPW;
  localparam int unsigned SW   = ((TW > SCORE_W) ? TW : SCORE_W) + 1;
  localparam int unsigned KW   = INDEX_W + SCORE_W;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_INS_CMP = 2'd1;
  localparam logic [1:0] ST_INS_PUT = 2'd2;
  localparam logic [1:0] ST_REP     = 2'd3;

  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  // ---------------------------------------------------------------- registers
  logic                  metric_q;
  logic [KEEP_REG_W-1:0] keep_q;
  logic [LEN_REG_W-1:0]  vlen_q;
  logic                  cfg_wr;
  logic [REG_IDX_W-1:0]  cfg_idx;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[APB_AW-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= 1'b0;
      keep_q   <= KEEP_RESET;
      vlen_q   <= LEN_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_METRIC: metric_q <= pwdata[0];
        REG_KEEP:   keep_q   <= pwdata[KEEP_REG_W-1:0];
        REG_LEN:    vlen_q   <= pwdata[LEN_REG_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_METRIC: prdata = APB_DW'(metric_q);
      REG_KEEP:   prdata = APB_DW'(keep_q);
      REG_LEN:    prdata = APB_DW'(vlen_q);
      default:    prdata = '0;
    endcase
  end

  // -------------------------------------------------------- derived settings
  logic [31:0]    vlen32, len_eff32, keep32, keep_eff32, pos32, elem32;
  logic [KFW-1:0] keep_eff;
  logic           pos_last, pos_in_store;

  assign vlen32    = 32'(vlen_q);
  assign len_eff32 = (vlen32 == 32'd0) ? 32'd1 :
                     (vlen32 > 32'(MAX_VECTOR_LENGTH)) ? 32'(MAX_VECTOR_LENGTH) : vlen32;
  assign keep32     = 32'(keep_q);
  assign keep_eff32 = (keep32 == 32'd0) ? 32'd1 :
                      (keep32 > 32'(MAX_KEPT)) ? 32'(MAX_KEPT) : keep32;
  assign keep_eff   = keep_eff32[KFW-1:0];

  assign pos32        = 32'(element_position_i);
  assign elem32       = {{(32-VALUE_W){1'b0}}, element_value_i};
  assign pos_last     = (pos32 == len_eff32 - 32'd1);
  assign pos_in_store = (pos32 < 32'(MAX_VECTOR_LENGTH));

  // ------------------------------------------------------------- control state
  logic [1:0]                state_q, state_d;
  logic                      s1_vld_q, s1_last_q, s1_qz_q;
  logic [ELEMENT_BITS-1:0]   s1_e_q;
  logic                      s2_vld_q, s2_last_q;
  logic signed [TW-1:0]      s2_term_q;
  logic signed [SCORE_W-1:0] acc_q, acc_d;
  logic [CNTW-1:0]           cnt_q, cnt_d;
  logic [KFW-1:0]            fill_q, fill_d, fill_eff;
  logic [KFW-1:0]            slot_q, slot_d, slot_m1, slot_m2, fill_m1;
  logic signed [SCORE_W-1:0] ins_score_q, ins_score_d;
  logic [INDEX_W-1:0]        ins_idx_q, ins_idx_d;
  logic [KFW-1:0]            rep_idx_q, rep_idx_d, rep_n_q, rep_n_d, rep_n_m1;
  logic                      res_q, res_d, res_last_q, res_last_d, res_empty_q, res_empty_d;

  logic acc_ok, is_query, is_data, is_report;

  assign busy      = (state_q != ST_IDLE) || s1_last_q || s2_last_q;
  assign acc_ok    = start && !busy;
  assign is_query  = acc_ok && (cmd_i == CMD_QUERY);
  assign is_data   = acc_ok && (cmd_i == CMD_DATA);
  assign is_report = acc_ok && (cmd_i == CMD_REPORT);

  // ------------------------------------------------------------ query memory
  logic [ELEMENT_BITS-1:0] q_rdata;

  tvss_ram #(
    .WIDTH (ELEMENT_BITS),
    .DEPTH (MAX_VECTOR_LENGTH),
    .AW    (QAW)
  ) u_query_ram (
    .clk_i   (clk_i),
    .we_i    (is_query && pos_in_store),
    .waddr_i (pos32[QAW-1:0]),
    .wdata_i (elem32[ELEMENT_BITS-1:0]),
    .re_i    (is_data),
    .raddr_i (pos32[QAW-1:0]),
    .rdata_o (q_rdata)
  );

  // ---------------------------------------------------- multiply / accumulate
  logic [ELEMENT_BITS-1:0] q_val;
  logic signed [OPW-1:0]   q_s, e_s, diff, op_a, op_b;
  logic signed [TW-1:0]    prod;
  logic signed [SW-1:0]    sum_w;
  logic [SW-SCORE_W:0]     sum_top;
  logic signed [SCORE_W-1:0] sum_sat;

  assign q_val = s1_qz_q ? '0 : q_rdata;
  assign q_s   = $signed({q_val[ELEMENT_BITS-1], q_val});
  assign e_s   = $signed({s1_e_q[ELEMENT_BITS-1], s1_e_q});
  assign diff  = q_s - e_s;
  assign op_a  = metric_q ? q_s : diff;
  assign op_b  = metric_q ? e_s : diff;
  assign prod  = op_a * op_b;

  assign sum_w   = SW'(acc_q) + SW'(s2_term_q);
  assign sum_top = sum_w[SW-1:SCORE_W-1];
  always_comb begin
    if ((&sum_top) || (~|sum_top)) begin
      sum_sat = sum_w[SCORE_W-1:0];
    end else if (sum_w[SW-1]) begin
      sum_sat = SCORE_MIN;
    end else begin
      sum_sat = SCORE_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
      s2_vld_q  <= 1'b0;
      s2_last_q <= 1'b0;
    end else if (is_report) begin
      // abandon any partly received vector
      s1_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
      s2_vld_q  <= 1'b0;
      s2_last_q <= 1'b0;
    end else begin
      s1_vld_q  <= is_data;
      s1_last_q <= is_data && pos_last;
      s2_vld_q  <= s1_vld_q;
      s2_last_q <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_data) begin
      s1_e_q  <= elem32[ELEMENT_BITS-1:0];
      s1_qz_q <= !pos_in_store;
    end
    s2_term_q <= prod;
  end

  // ------------------------------------------------------- kept-list memory
  kept_t          k_rdata, k_wdata, new_entry;
  logic           k_we, k_re;
  logic [KAW-1:0] k_waddr, k_raddr;
  logic           beat;
  logic [31:0]    cnt32;

  tvss_ram #(
    .WIDTH (KW),
    .DEPTH (MAX_KEPT),
    .AW    (KAW)
  ) u_kept_ram (
    .clk_i   (clk_i),
    .we_i    (k_we),
    .waddr_i (k_waddr),
    .wdata_i (k_wdata),
    .re_i    (k_re),
    .raddr_i (k_raddr),
    .rdata_o (k_rdata)
  );

  assign fill_eff  = (fill_q < keep_eff) ? fill_q : keep_eff;
  assign fill_m1   = fill_eff - KFW'(1);
  assign slot_m1   = slot_q - KFW'(1);
  assign slot_m2   = slot_q - KFW'(2);
  assign rep_n_m1  = rep_n_q - KFW'(1);
  assign cnt32     = 32'(cnt_q);
  assign new_entry = '{idx: ins_idx_q, score: ins_score_q};

  // list is ascending in distance mode, descending in dot mode
  assign beat = metric_q ? (ins_score_q >= k_rdata.score) : (ins_score_q < k_rdata.score);

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    fill_d      = fill_q;
    slot_d      = slot_q;
    ins_score_d = ins_score_q;
    ins_idx_d   = ins_idx_q;
    rep_idx_d   = rep_idx_q;
    rep_n_d     = rep_n_q;
    res_d       = 1'b0;
    res_last_d  = res_last_q;
    res_empty_d = res_empty_q;
    k_we        = 1'b0;
    k_waddr     = slot_q[KAW-1:0];
    k_wdata     = new_entry;
    k_re        = 1'b0;
    k_raddr     = slot_m1[KAW-1:0];

    if (is_report) begin
      acc_d  = '0;
      cnt_d  = '0;
      fill_d = '0;
      if (fill_eff == '0) begin
        res_d       = 1'b1;
        res_last_d  = 1'b1;
        res_empty_d = 1'b1;
      end else begin
        rep_n_d   = fill_eff;
        rep_idx_d = '0;
        state_d   = ST_REP;
      end
    end else if (s2_vld_q) begin
      if (s2_last_q) begin
        acc_d = '0;
        if (cnt_q < CNTW'(MAX_ENTRIES)) begin
          cnt_d       = cnt_q + CNTW'(1);
          ins_score_d = sum_sat;
          ins_idx_d   = cnt32[INDEX_W-1:0];
          fill_d      = (fill_eff < keep_eff) ? fill_eff + KFW'(1) : keep_eff;
          slot_d      = fill_eff;
          if (fill_eff == '0) begin
            state_d = ST_INS_PUT;
          end else begin
            k_re    = 1'b1;
            k_raddr = fill_m1[KAW-1:0];
            state_d = ST_INS_CMP;
          end
        end
      end else begin
        acc_d = sum_sat;
      end
    end

    case (state_q)
      ST_IDLE: ;
      ST_INS_CMP: begin
        if (beat) begin
          // shift the compared entry down one slot; the tail one falls off
          k_we    = (slot_q < keep_eff);
          k_wdata = k_rdata;
          slot_d  = slot_m1;
          if (slot_q == KFW'(1)) begin
            state_d = ST_INS_PUT;
          end else begin
            k_re    = 1'b1;
            k_raddr = slot_m2[KAW-1:0];
          end
        end else begin
          k_we    = (slot_q < keep_eff);
          state_d = ST_IDLE;
        end
      end
      ST_INS_PUT: begin
        k_we    = 1'b1;
        state_d = ST_IDLE;
      end
      ST_REP: begin
        k_re        = 1'b1;
        k_raddr     = rep_idx_q[KAW-1:0];
        res_d       = 1'b1;
        res_empty_d = 1'b0;
        res_last_d  = (rep_idx_q == rep_n_m1);
        rep_idx_d   = rep_idx_q + KFW'(1);
        if (rep_idx_q == rep_n_m1) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      cnt_q       <= '0;
      fill_q      <= '0;
      res_q       <= 1'b0;
      res_last_q  <= 1'b0;
      res_empty_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      fill_q      <= fill_d;
      res_q       <= res_d;
      res_last_q  <= res_last_d;
      res_empty_q <= res_empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q      <= slot_d;
    ins_score_q <= ins_score_d;
    ins_idx_q   <= ins_idx_d;
    rep_idx_q   <= rep_idx_d;
    rep_n_q     <= rep_n_d;
  end

  // ------------------------------------------------------------------ results
  assign result_valid_o = res_q;
  assign last_result_o  = res_last_q;
  assign entry_valid_o  = !res_empty_q;
  assign entry_index_o  = res_empty_q ? '0 : k_rdata.idx;
  assign entry_score_o  = res_empty_q ? '0 : k_rdata.score;

endmodule

@@ rtl/core/tvss_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tvss_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/tvss_chk.sv @@
// Port-level checker for the top-k similarity search core, bound to the top level.
// Depends on tvss_pkg for field widths and command codes.
module tvss_chk
  import tvss_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic [CMD_W-1:0]          cmd_i,
  input logic                      result_valid_o,
  input logic                      entry_valid_o,
  input logic                      last_result_o
);

  // a report run is one unbroken burst of transfers
  a_burst_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_result_o |=> result_valid_o)
    else $error("report burst broken before its last transfer");

  // an empty-list report is a single transfer
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !entry_valid_o |-> last_result_o)
    else $error("empty report result not marked last");

  // an accepted report either streams or answers empty at once
  a_report_response: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (cmd_i == CMD_REPORT) |=> busy || result_valid_o)
    else $error("report accepted without response");

  // mid-burst, no new command can slip in
  a_busy_mid_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_result_o |-> busy)
    else $error("core idle in the middle of a report burst");

endmodule

bind topk_vector_similarity_search tvss_chk u_tvss_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .cmd_i          (cmd_i),
  .result_valid_o (result_valid_o),
  .entry_valid_o  (entry_valid_o),
  .last_result_o  (last_result_o)
);

@@ test/tb_topk_vector_similarity_search.sv @@
// Self-checking testbench for topk_vector_similarity_search: directed and random command
// streams, APB register setup, and an in-bench predictor of the ranked list and its reports.
// Depends on tvss_pkg and the RTL under rtl/core.
module tb_topk_vector_similarity_search;
  import tvss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_LEN      = DEF_MAX_VECTOR_LENGTH;
  localparam int unsigned MAX_KEEP_N   = DEF_MAX_KEPT;
  localparam int unsigned MAX_VECTORS  = DEF_MAX_ENTRIES;
  localparam int unsigned IDLE_HOLDOFF = 80;   // > longest ranked insert plus pipeline
  localparam int unsigned END_LIMIT    = 20000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam longint SCORE_TOP    = 64'sd8796093022207;
  localparam longint SCORE_BOTTOM = -SCORE_TOP - 1;

  typedef struct {
    logic [INDEX_W-1:0] entry_idx;
    logic [SCORE_W-1:0] score;
    logic               valid;
    logic               last;
  } ranked_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [CMD_W-1:0]          cmd_i = '0;
  logic signed [VALUE_W-1:0] element_value_i = '0;
  logic [POS_W-1:0]          element_position_i = '0;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [APB_AW-1:0]         paddr = '0;
  logic [APB_DW-1:0]         pwdata = '0;
  logic [APB_DW-1:0]         prdata;
  logic                      pready;
  logic                      result_valid_o;
  logic [INDEX_W-1:0]        entry_index_o;
  logic signed [SCORE_W-1:0] entry_score_o;
  logic                      entry_valid_o;
  logic                      last_result_o;

  topk_vector_similarity_search u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .cmd_i              (cmd_i),
    .element_value_i    (element_value_i),
    .element_position_i (element_position_i),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .result_valid_o     (result_valid_o),
    .entry_index_o      (entry_index_o),
    .entry_score_o      (entry_score_o),
    .entry_valid_o      (entry_valid_o),
    .last_result_o      (last_result_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state: registers, query store, running score and ranked list
  logic                      cfg_dot = 1'b0;
  logic [KEEP_REG_W-1:0]     cfg_keep = KEEP_RESET;
  logic [LEN_REG_W-1:0]      cfg_len = LEN_RESET;
  logic signed [VALUE_W-1:0] query_mem [MAX_LEN];
  bit                        query_written [MAX_LEN];
  longint                    acc_score = 0;
  int unsigned               vectors_seen = 0;
  longint                    list_score [MAX_KEEP_N];
  logic [INDEX_W-1:0]        list_idx [MAX_KEEP_N];
  int unsigned               list_fill = 0;

  ranked_result_t            expected_results [$];
  int unsigned               error_count = 0;
  int unsigned               items_sent = 0;
  int unsigned               sender_idle_pct = 38;

  function automatic void queue_expected(input ranked_result_t r);
    expected_results = {expected_results, r};
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 100) $display("%0t ERROR %s", $time, msg);
  endtask

  function automatic int unsigned keep_limit();
    int unsigned k;
    k = 32'(cfg_keep);
    if (k == 0) k = 1;
    if (k > MAX_KEEP_N) k = MAX_KEEP_N;
    return k;
  endfunction

  function automatic int unsigned len_limit();
    int unsigned n;
    n = 32'(cfg_len);
    if (n == 0) n = 1;
    if (n > MAX_LEN) n = MAX_LEN;
    return n;
  endfunction

  // Dot product keeps the largest, newest first on ties; distance keeps the smallest, oldest first
  function automatic bit ranks_above(input longint fresh, input longint old);
    if (cfg_dot) return fresh >= old;
    return fresh < old;
  endfunction

  function automatic void rank_insert(input longint score, input logic [INDEX_W-1:0] idx);
    int unsigned k, fill, p, i;
    k = keep_limit();
    fill = (list_fill < k) ? list_fill : k;
    p = 0;
    while (p < fill && !ranks_above(score, list_score[p])) p++;
    if (p >= k) begin
      list_fill = fill;
      return;
    end
    i = (fill < k) ? fill : k - 1;
    while (i > p) begin
      list_score[i] = list_score[i-1];
      list_idx[i]   = list_idx[i-1];
      i--;
    end
    list_score[p] = score;
    list_idx[p]   = idx;
    list_fill = (fill < k) ? fill + 1 : k;
  endfunction

  function automatic void predict_item(input logic [CMD_W-1:0] cmd,
                                       input logic signed [VALUE_W-1:0] value,
                                       input logic [POS_W-1:0] pos);
    longint q, e, term;
    int unsigned n, j;
    ranked_result_t r;
    case (cmd)
      CMD_QUERY: begin
        query_mem[pos] = value;
        query_written[pos] = 1'b1;
      end
      CMD_DATA: begin
        q = longint'(query_mem[pos]);
        e = longint'(value);
        if (cfg_dot) term = q * e;
        else term = (q - e) * (q - e);
        acc_score += term;
        if (acc_score > SCORE_TOP) acc_score = SCORE_TOP;
        if (acc_score < SCORE_BOTTOM) acc_score = SCORE_BOTTOM;
        if (32'(pos) == len_limit() - 1) begin
          if (vectors_seen < MAX_VECTORS) begin
            rank_insert(acc_score, vectors_seen[INDEX_W-1:0]);
            vectors_seen++;
          end
          acc_score = 0;
        end
      end
      CMD_REPORT: begin
        n = (list_fill < keep_limit()) ? list_fill : keep_limit();
        if (n == 0) begin
          r.entry_idx = '0;
          r.score     = '0;
          r.valid     = 1'b0;
          r.last      = 1'b1;
          queue_expected(r);
        end
        for (j = 0; j < n; j++) begin
          r.entry_idx = list_idx[j];
          r.score     = list_score[j][SCORE_W-1:0];
          r.valid     = 1'b1;
          r.last      = (j + 1 == n);
          queue_expected(r);
        end
        list_fill = 0;
        vectors_seen = 0;
        acc_score = 0;
      end
      default: ;
    endcase
  endfunction

  // One command transfer; optional idle gap first, start stays high across back-to-back items
  task automatic send_item(input logic [CMD_W-1:0] cmd,
                           input logic signed [VALUE_W-1:0] value,
                           input logic [POS_W-1:0] pos);
    int unsigned gap;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start              <= 1'b1;
    cmd_i              <= cmd;
    element_value_i    <= value;
    element_position_i <= pos;
    do @(posedge clk_i); while (busy !== 1'b0);
    predict_item(cmd, value, pos);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      default: return r[VALUE_W-1:0];
    endcase
  endfunction

  // Positions 0..n-1 in order with random values
  task automatic send_run(input logic [CMD_W-1:0] cmd, input int unsigned n);
    int unsigned p;
    for (p = 0; p < n; p++) send_item(cmd, pick_value(), p[POS_W-1:0]);
  endtask

  // Stop sending and wait for all reports; hold_off also covers a trailing ranked insert
  task automatic settle(input bit hold_off);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    if (hold_off) repeat (IDLE_HOLDOFF) @(posedge clk_i);
  endtask

  // APB write followed by a read-back of the same register
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] mask;
    case (idx)
      REG_METRIC: mask = 32'h1;
      REG_KEEP:   mask = 32'h7F;
      default:    mask = 32'h7FF;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    case (idx)
      REG_METRIC: cfg_dot  = value[0];
      REG_KEEP:   cfg_keep = value[KEEP_REG_W-1:0];
      REG_LEN:    cfg_len  = value[LEN_REG_W-1:0];
      default: ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata !== (value & mask))
      flag_error($sformatf("register %0d read back %0h, expected %0h", idx, prdata,
                           value & mask));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk_i) begin : check_results
    ranked_result_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (expected_results.size() == 0) begin
        flag_error($sformatf("result with nothing pending, index %0d", entry_index_o));
      end else begin
        want = expected_results.pop_front();
        if (entry_index_o !== want.entry_idx)
          flag_error($sformatf("entry_index %0d, expected %0d", entry_index_o, want.entry_idx));
        if (entry_score_o !== want.score)
          flag_error($sformatf("entry_score %0d, expected %0d (index %0d)", entry_score_o,
                               $signed(want.score), want.entry_idx));
        if (entry_valid_o !== want.valid)
          flag_error($sformatf("entry_valid %b, expected %b", entry_valid_o, want.valid));
        if (last_result_o !== want.last)
          flag_error($sformatf("last_result %b, expected %b (index %0d)", last_result_o,
                               want.last, want.entry_idx));
      end
    end
  end

  task automatic test_empty_report();
    send_item(CMD_REPORT, '0, '0);
  endtask

  // Reset length ends a vector at position 1023; an over-range length register does the same
  task automatic test_full_length();
    send_item(CMD_QUERY, pick_value(), 10'd0);
    send_item(CMD_QUERY, pick_value(), 10'd1022);
    send_item(CMD_QUERY, pick_value(), 10'd1023);
    send_item(CMD_DATA, pick_value(), 10'd0);
    send_item(CMD_DATA, pick_value(), 10'd1023);
    send_item(CMD_DATA, pick_value(), 10'd1023);
    send_item(CMD_REPORT, '0, '0);
    settle(1'b1);
    write_reg(REG_LEN, 32'd2047);
    send_item(CMD_DATA, pick_value(), 10'd0);
    send_item(CMD_DATA, pick_value(), 10'd1022);
    send_item(CMD_DATA, pick_value(), 10'd1023);
    send_item(CMD_REPORT, '0, '0);
  endtask

  task automatic test_distance_ranking();
    settle(1'b1);
    write_reg(REG_METRIC, 32'd0);
    write_reg(REG_KEEP, 32'd4);
    write_reg(REG_LEN, 32'd3);
    send_item(CMD_QUERY, 16'sh8000, 10'd0);
    send_item(CMD_QUERY, 16'sh7FFF, 10'd1);
    send_item(CMD_QUERY, 16'sh0000, 10'd2);
    // identical vectors twice: equal distance, older stays ahead
    repeat (2) begin
      send_item(CMD_DATA, 16'sh8000, 10'd0);
      send_item(CMD_DATA, 16'sh7FFF, 10'd1);
      send_item(CMD_DATA, 16'sh0000, 10'd2);
    end
    send_item(CMD_DATA, 16'sh7FFF, 10'd0);
    send_item(CMD_DATA, 16'sh8000, 10'd1);
    send_item(CMD_DATA, 16'sh8000, 10'd2);
    send_item(CMD_UNUSED, 16'sh7FFF, 10'h3FF);
    repeat (3) send_run(CMD_DATA, 3);
    send_item(CMD_REPORT, '0, '0);
  endtask

  task automatic test_dot_ranking();
    settle(1'b1);
    write_reg(REG_METRIC, 32'd1);
    write_reg(REG_KEEP, 32'd3);
    write_reg(REG_LEN, 32'd2);
    send_item(CMD_QUERY, 16'sh7FFF, 10'd0);
    send_item(CMD_QUERY, 16'sh8000, 10'd1);
    send_item(CMD_DATA, 16'sh7FFF, 10'd0);
    send_item(CMD_DATA, 16'sh8000, 10'd1);
    // equal scores: newer entry goes ahead
    repeat (2) begin
      send_item(CMD_DATA, 16'sh0000, 10'd0);
      send_item(CMD_DATA, 16'sh0000, 10'd1);
    end
    send_item(CMD_DATA, 16'sh8000, 10'd0);
    send_item(CMD_DATA, 16'sh7FFF, 10'd1);
    // report with a vector half received
    send_item(CMD_DATA, 16'sh0005, 10'd0);
    send_item(CMD_REPORT, '0, '0);
    send_item(CMD_DATA, 16'sh0064, 10'd0);
    send_item(CMD_DATA, 16'sh0000, 10'd1);
    send_item(CMD_UNUSED, '0, '0);
    send_item(CMD_REPORT, '0, '0);
  endtask

  task automatic test_keep_limits();
    settle(1'b1);
    write_reg(REG_METRIC, 32'd0);
    write_reg(REG_KEEP, 32'd0);
    write_reg(REG_LEN, 32'd0);
    send_item(CMD_QUERY, pick_value(), 10'd0);
    send_run(CMD_DATA, 3);
    send_item(CMD_DATA, pick_value(), 10'd0);
    send_item(CMD_REPORT, '0, '0);
    settle(1'b1);
    write_reg(REG_KEEP, 32'd127);
    repeat (70) send_item(CMD_DATA, pick_value(), 10'd0);
    send_item(CMD_REPORT, '0, '0);
    settle(1'b1);
    write_reg(REG_KEEP, 32'd8);
    write_reg(REG_LEN, 32'd3);
    send_run(CMD_QUERY, 3);
    repeat (6) send_run(CMD_DATA, 3);
    settle(1'b1);
    write_reg(REG_KEEP, 32'd3);
    send_item(CMD_REPORT, '0, '0);
    settle(1'b1);
    write_reg(REG_KEEP, 32'd8);
    repeat (5) send_run(CMD_DATA, 3);
    settle(1'b1);
    write_reg(REG_KEEP, 32'd2);
    send_run(CMD_DATA, 3);
    settle(1'b1);
    write_reg(REG_KEEP, 32'd8);
    send_item(CMD_REPORT, '0, '0);
    settle(1'b1);
    write_reg(REG_KEEP, 32'd64);
  endtask

  task automatic run_random(input int unsigned pct, input int unsigned target);
    int unsigned first, len, r;
    logic [KEEP_REG_W-1:0] keep;
    logic [LEN_REG_W-1:0] vlen;
    logic [POS_W-1:0] pos;
    sender_idle_pct = pct;
    first = items_sent;
    while (items_sent - first < target) begin
      settle(1'b1);
      case ($urandom_range(0, 9))
        0: keep = 7'd0;
        1: keep = 7'd64;
        2: keep = 7'($urandom_range(65, 127));
        3: keep = 7'd1;
        default: keep = 7'($urandom_range(2, 8));
      endcase
      case ($urandom_range(0, 9))
        0: vlen = 11'd0;
        1: vlen = 11'($urandom_range(7, 24));
        2: vlen = 11'd1;
        default: vlen = 11'($urandom_range(2, 6));
      endcase
      write_reg(REG_METRIC, $urandom_range(0, 1));
      write_reg(REG_KEEP, {25'd0, keep});
      write_reg(REG_LEN, {21'd0, vlen});
      len = len_limit();
      send_run(CMD_QUERY, len);
      repeat ($urandom_range(4, 14)) begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          send_run(CMD_DATA, len);
        end else if (r < 77) begin
          send_item(CMD_REPORT, pick_value(), POS_W'($urandom));
          if ($urandom_range(0, 2) == 0) settle(1'b0);
        end else if (r < 84) begin
          pos = POS_W'($urandom);
          if (!query_written[pos]) pos = POS_W'($urandom_range(0, len - 1));
          send_item(CMD_DATA, pick_value(), pos);
        end else if (r < 90) begin
          send_item(CMD_QUERY, pick_value(), POS_W'($urandom));
        end else if (r < 95) begin
          send_run(CMD_DATA, $urandom_range(0, len - 1));
          send_item(CMD_REPORT, '0, '0);
        end else begin
          send_item(CMD_UNUSED, pick_value(), POS_W'($urandom));
        end
      end
      send_item(CMD_REPORT, '0, '0);
    end
  endtask

  initial begin : test_sequence
    int unsigned n;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_report();
    test_full_length();
    test_distance_ranking();
    test_dot_ranking();
    test_keep_limits();
    run_random(38, 90);
    run_random(52, 90);
    run_random(0, 90);
    start <= 1'b0;
    for (n = 0; n < END_LIMIT && expected_results.size() != 0; n++) @(posedge clk_i);
    repeat (IDLE_HOLDOFF) @(posedge clk_i);
    if (expected_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", expected_results.size()));
    if (error_count == 0) begin
      $display("tb_topk_vector_similarity_search passed");
    end else begin
      $display("tb_topk_vector_similarity_search failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb_topk_vector_similarity_search failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/tvss_pkg.sv
rtl/core/tvss_ram.sv
rtl/core/topk_vector_similarity_search.sv
rtl/core/tvss_chk.sv
test/tb_topk_vector_similarity_search.sv
